### rtl/core/cqs_pkg.sv
// Package for the circular queue with search.
// Holds the item types, opcode and status codes, and cell control struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cqs_pkg;

  // Width of a stored value.
  localparam int unsigned VALUE_W = 32;

  // Width of the capacity register and its value after reset.
  localparam int unsigned QSIZE_W = 5;
  localparam logic [QSIZE_W-1:0] QSIZE_RESET = 5'd16;

  // Width of the position field in a result item.
  localparam int unsigned POS_W = 4;

  // Command codes.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // One command item.
  typedef struct packed {
    logic [1:0]                opcode;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  // One result item.
  typedef struct packed {
    status_t                   status;
    logic signed [VALUE_W-1:0] data;
    logic [POS_W-1:0]          position;
  } out_item_t;

  // Controls broadcast from the sequencer to every cell.
  typedef struct packed {
    logic load;     // write the new value into the selected cell
    logic shift;    // every cell takes the value of its younger neighbor
    logic capture;  // every cell compares its value with the search key
    logic scan;     // match flags move one cell toward the oldest end
  } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/core/cqs_cell.sv
// One cell of the queue chain: a stored value and a search match flag.
// Depends on cqs_pkg for the control struct and value width.
`timescale 1ns / 1ps
`default_nettype none

module cqs_cell (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire cqs_pkg::cell_ctrl_t           ctrl,
  input  wire logic                          sel,
  input  wire logic                          in_use,
  input  wire logic signed [cqs_pkg::VALUE_W-1:0] din,
  input  wire logic signed [cqs_pkg::VALUE_W-1:0] nbr_value,
  input  wire logic                          nbr_match,
  output logic signed [cqs_pkg::VALUE_W-1:0] value,
  output logic                               match
);

  import cqs_pkg::*;

  // Stored value: loaded on insert, shifted toward the head on delete.
  always_ff @(posedge clk) begin
    if (ctrl.load && sel) begin
      value <= din;
    end else if (ctrl.shift) begin
      value <= nbr_value;
    end
  end

  // Match flag: set by comparison with the key, then walked toward the head.
  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctrl.capture) begin
      match <= in_use && (value == din);
    end else if (ctrl.scan) begin
      match <= nbr_match;
    end
  end

endmodule

`default_nettype wire

### rtl/core/circular_queue_with_search.sv
// Top level of the circular queue with search: sequencer, cell chain, result stages.
// Depends on cqs_pkg and cqs_cell.
//
// Usage:
// Commands enter on in_valid/in_stall with in_item (opcode, value); each item
// yields exactly one result item on out_valid/out_stall with out_item
// (status, data, position). The queue is kept in a row of DEPTH cells ordered
// by age, the oldest in cell 0; a delete shifts the whole row one cell.
// Insert, delete and the unused opcode finish in the cycle they are accepted;
// their result passes through the result stage and the output register, and
// no new item is taken while a result waits in the result stage. A search
// compares all cells at once, then walks the match flags down the chain one
// cell a cycle until a match reaches cell 0 or the walk passes the last entry.
// A result stage sits in front of the output register, so an item is
// accepted while an earlier result waits on a stalled receiver; with both
// stages full, in_stall stays high until out_stall falls.
// Writing cfg_data sets the capacity (0 acts as 1, above DEPTH acts as DEPTH)
// and empties the queue. Reset empties the queue, sets the capacity to 16
// and clears both result stages.
`timescale 1ns / 1ps
`default_nettype none

module circular_queue_with_search #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire cqs_pkg::in_item_t             in_item,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output cqs_pkg::out_item_t                 out_item,
  input  wire logic                          cfg_we,
  input  wire logic [cqs_pkg::QSIZE_W-1:0]   cfg_data
);

  import cqs_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t                    state;
  logic [QSIZE_W-1:0]        queue_size;
  logic [CW-1:0]             count;
  logic [CW-1:0]             cap;
  logic [CW-1:0]             scan_pos;
  logic                      res_valid;
  out_item_t                 res_item;
  out_item_t                 res_next;
  logic                      res_set;
  logic                      res_take;
  logic                      in_acc;
  logic                      full;
  logic                      empty;
  logic                      scan_end;
  cell_ctrl_t                ctrl;
  logic signed [VALUE_W-1:0] chain_value [DEPTH+1];
  logic                      chain_match [DEPTH+1];

  // Effective capacity, clamped to the range 1 to DEPTH.
  always_comb begin
    if (32'(queue_size) > DEPTH) begin
      cap = CW'(DEPTH);
    end else if (queue_size == '0) begin
      cap = CW'(1);
    end else begin
      cap = CW'(queue_size);
    end
  end

  assign full      = (count >= cap);
  assign empty     = (count == '0);
  assign in_stall  = (state != S_IDLE) || res_valid;
  assign in_acc    = in_valid && !in_stall;
  assign scan_end  = (state == S_SCAN) && ((scan_pos == count) || chain_match[0]);
  assign res_take  = res_valid && (!out_valid || !out_stall);

  // Controls broadcast to the cell chain.
  always_comb begin
    ctrl.load    = in_acc && (in_item.opcode == OP_INSERT) && !full;
    ctrl.shift   = in_acc && (in_item.opcode == OP_DELETE) && !empty;
    ctrl.capture = in_acc && (in_item.opcode == OP_SEARCH);
    ctrl.scan    = (state == S_SCAN) && !scan_end;
  end

  // Result of the command that finishes in this cycle.
  always_comb begin
    res_next.status   = ST_OK;
    res_next.data     = '0;
    res_next.position = '0;
    res_set           = 1'b0;
    if (scan_end) begin
      res_set = 1'b1;
      if (chain_match[0] && (scan_pos != count)) begin
        res_next.position = POS_W'(scan_pos);
      end else begin
        res_next.status = ST_NOT_FOUND;
      end
    end else if (in_acc) begin
      case (in_item.opcode)
        OP_INSERT: begin
          res_set = 1'b1;
          if (full) begin
            res_next.status = ST_FULL;
          end
        end
        OP_DELETE: begin
          res_set = 1'b1;
          if (empty) begin
            res_next.status = ST_EMPTY;
          end else begin
            res_next.data = chain_value[0];
          end
        end
        OP_SEARCH: begin
          res_set = 1'b0;
        end
        default: begin
          res_set = 1'b1;
        end
      endcase
    end
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else if (ctrl.capture) begin
      state <= S_SCAN;
    end else if (scan_end) begin
      state <= S_IDLE;
    end
  end

  // Scan offset from the oldest entry.
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      scan_pos <= '0;
    end else if (ctrl.scan) begin
      scan_pos <= scan_pos + CW'(1);
    end
  end

  // Capacity register and entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      queue_size <= QSIZE_RESET;
      count      <= '0;
    end else if (cfg_we) begin
      queue_size <= cfg_data;
      count      <= '0;
    end else if (ctrl.load) begin
      count <= count + CW'(1);
    end else if (ctrl.shift) begin
      count <= count - CW'(1);
    end
  end

  // Result stage ahead of the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_set) begin
      res_valid <= 1'b1;
    end else if (res_take) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_set) begin
      res_item <= res_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_item <= res_item;
    end
  end

  // Chain of cells, oldest entry in cell 0; the end of the chain reads zero.
  assign chain_value[DEPTH] = '0;
  assign chain_match[DEPTH] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cqs_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .sel       (count == CW'(i)),
      .in_use    (CW'(i) < count),
      .din       (in_item.value),
      .nbr_value (chain_value[i+1]),
      .nbr_match (chain_match[i+1]),
      .value     (chain_value[i]),
      .match     (chain_match[i])
    );
  end

  // The queue never holds more entries than its capacity.
  assert property (@(posedge clk) disable iff (rst) count <= cap)
    else $error("entry count above capacity");

  // A search always enters the scan state.
  assert property (@(posedge clk) disable iff (rst) ctrl.capture |=> state == S_SCAN)
    else $error("search did not start a scan");

  // The scan never runs past the occupied entries.
  assert property (@(posedge clk) disable iff (rst) state == S_SCAN |-> scan_pos <= count)
    else $error("scan offset beyond entry count");

  // A waiting result is neither lost nor altered.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_take |=> res_valid && $stable(res_item))
    else $error("pending result lost or changed");

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Testbench for circular_queue_with_search: directed and random command items are
// checked field by field against a behavioral queue model kept in this file.
// Depends on cqs_pkg and the circular_queue_with_search RTL.

module testbench;
  import cqs_pkg::*;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned MAX_WAIT = 12;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_ITEMS = 60;

  // Block inputs start at known values.
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [QSIZE_W-1:0] cfg_data = '0;

  // Model of the queue contents and capacity register.
  logic signed [VALUE_W-1:0] slot_mem [DEPTH];
  int unsigned head_idx = 0;
  int unsigned tail_idx = 0;
  int unsigned fill_count = 0;
  logic [QSIZE_W-1:0] qsize_reg = QSIZE_RESET;

  // Results predicted but not yet seen on the output, oldest first.
  out_item_t pending_results[$];

  bit cmd_live = 1'b0;
  bit no_idle = 1'b0;
  int unsigned stall_left = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned cmd_count = 0;
  int unsigned status_seen [4] = '{0, 0, 0, 0};

  circular_queue_with_search #(.DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Run limit, generous against the slowest legal run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles.", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  // Idle cycles before an item or between results; zero during burst stretches.
  function automatic int unsigned pick_wait();
    if (no_idle) begin
      return 0;
    end
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // Capacity in effect: zero acts as one, anything above DEPTH acts as DEPTH.
  function automatic int unsigned queue_capacity();
    int unsigned c;
    c = qsize_reg;
    if (c < 1) c = 1;
    if (c > DEPTH) c = DEPTH;
    return c;
  endfunction

  function automatic int unsigned wrap_next(input int unsigned idx);
    return (idx + 1 >= queue_capacity()) ? 0 : idx + 1;
  endfunction

  // Value held k entries after the oldest one.
  function automatic logic [VALUE_W-1:0] stored_at(input int unsigned k);
    int unsigned idx;
    idx = head_idx;
    repeat (k) idx = wrap_next(idx);
    return slot_mem[idx];
  endfunction

  function automatic in_item_t make_cmd(input logic [1:0] op, input logic [VALUE_W-1:0] val);
    in_item_t c;
    c.opcode = op;
    c.value = val;
    return c;
  endfunction

  // Random value: mostly wide, with a small pool for duplicates and the extremes.
  function automatic logic [VALUE_W-1:0] random_value();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r < 4) return $urandom;
    if (r < 6) return $urandom_range(0, 7);
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // Updates the queue model for one accepted item and queues its result.
  task automatic predict_result(input in_item_t cmd);
    out_item_t res;
    int unsigned idx;
    bit hit;
    res = '0;
    hit = 1'b0;
    case (cmd.opcode)
      OP_INSERT: begin
        if (fill_count >= queue_capacity()) begin
          res.status = ST_FULL;
        end else begin
          slot_mem[tail_idx] = cmd.value;
          tail_idx = wrap_next(tail_idx);
          fill_count++;
        end
      end
      OP_DELETE: begin
        if (fill_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.data = slot_mem[head_idx];
          head_idx = wrap_next(head_idx);
          fill_count--;
        end
      end
      OP_SEARCH: begin
        idx = head_idx;
        for (int unsigned k = 0; k < fill_count && !hit; k++) begin
          if (slot_mem[idx] == cmd.value) begin
            hit = 1'b1;
            res.position = k[POS_W-1:0];
          end
          idx = wrap_next(idx);
        end
        res.status = hit ? ST_OK : ST_NOT_FOUND;
      end
      OP_NOP: begin
      end
      default: begin
      end
    endcase
    status_seen[res.status]++;
    pending_results.push_back(res);
  endtask

  task automatic report_mismatch(input string msg);
    $display("Mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // Compares one accepted result with the oldest prediction.
  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result status %0d data %h position %0d",
                                got.status, got.data, got.position));
    end else begin
      want = pending_results.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.data !== want.data)
        report_mismatch($sformatf("data %h, expected %h", got.data, want.data));
      if (got.position !== want.position)
        report_mismatch($sformatf("position %0d, expected %0d", got.position, want.position));
    end
  endtask

  // Receiver: checks each accepted result, then stalls for a random stretch.
  always @(posedge clk) begin
    if (rst) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        check_result(out_item);
        stall_left = pick_wait();
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0);
    end
  end

  // Lowers valid once the last item has been taken.
  task automatic drop_cmd();
    if (cmd_live) begin
      in_valid <= 1'b0;
      cmd_live = 1'b0;
    end
  endtask

  // Sends one item after a random gap and predicts its result on acceptance.
  task automatic send_cmd(input in_item_t cmd);
    int unsigned gap;
    gap = pick_wait();
    if (gap > 0) begin
      drop_cmd();
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= cmd;
    cmd_live = 1'b1;
    do @(posedge clk); while (in_stall);
    cmd_count++;
    predict_result(cmd);
  endtask

  // Holds off new items until every predicted result has come out.
  task automatic drain_results();
    drop_cmd();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Writes the capacity register with the block idle; this also empties the queue.
  task automatic set_capacity(input logic [QSIZE_W-1:0] sz);
    drain_results();
    repeat (2) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= sz;
    @(posedge clk);
    cfg_we <= 1'b0;
    qsize_reg = sz;
    head_idx = 0;
    tail_idx = 0;
    fill_count = 0;
  endtask

  // Default capacity after reset: empty cases, extreme values, first-match search.
  task automatic test_reset_state();
    send_cmd(make_cmd(OP_DELETE, 32'h0000_0000));
    send_cmd(make_cmd(OP_SEARCH, 32'h0000_0000));
    send_cmd(make_cmd(OP_NOP, 32'h7FFF_FFFF));
    send_cmd(make_cmd(OP_INSERT, 32'h8000_0000));
    send_cmd(make_cmd(OP_INSERT, 32'h7FFF_FFFF));
    send_cmd(make_cmd(OP_INSERT, 32'h0000_0000));
    send_cmd(make_cmd(OP_INSERT, 32'hFFFF_FFFF));
    send_cmd(make_cmd(OP_SEARCH, 32'hFFFF_FFFF));
    send_cmd(make_cmd(OP_INSERT, 32'h7FFF_FFFF));
    send_cmd(make_cmd(OP_SEARCH, 32'h7FFF_FFFF));
    send_cmd(make_cmd(OP_SEARCH, 32'h0000_0005));
    send_cmd(make_cmd(OP_DELETE, 32'hFFFF_FFFF));
    send_cmd(make_cmd(OP_SEARCH, 32'h7FFF_FFFF));
  endtask

  // Capacity zero acting as one, then a small capacity with the tail wrapping.
  task automatic test_capacity_edges();
    set_capacity(5'd0);
    send_cmd(make_cmd(OP_INSERT, 32'd11));
    send_cmd(make_cmd(OP_INSERT, 32'd22));
    send_cmd(make_cmd(OP_DELETE, 32'd0));
    send_cmd(make_cmd(OP_DELETE, 32'd0));
    set_capacity(5'd3);
    send_cmd(make_cmd(OP_INSERT, 32'd1));
    send_cmd(make_cmd(OP_INSERT, 32'd2));
    send_cmd(make_cmd(OP_INSERT, 32'd3));
    send_cmd(make_cmd(OP_INSERT, 32'd4));
    send_cmd(make_cmd(OP_DELETE, 32'd0));
    send_cmd(make_cmd(OP_DELETE, 32'd0));
    send_cmd(make_cmd(OP_INSERT, 32'd5));
    send_cmd(make_cmd(OP_INSERT, 32'd6));
    send_cmd(make_cmd(OP_SEARCH, 32'd6));
  endtask

  // Random traffic over a series of capacities, each phase with its own mix.
  task automatic test_random_traffic();
    logic [QSIZE_W-1:0] sizes [8];
    int unsigned ins_w, del_w, r;
    logic [VALUE_W-1:0] val;
    sizes = '{5'd31, 5'd16, 5'd1, 5'd2, 5'd17, 5'($urandom_range(0, 31)), 5'd0,
              5'($urandom_range(3, 16))};
    for (int p = 0; p < 8; p++) begin
      set_capacity(sizes[p]);
      case (p % 3)
        0: begin ins_w = 55; del_w = 15; end
        1: begin ins_w = 25; del_w = 45; end
        default: begin ins_w = 35; del_w = 30; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Switch between idling and burst stretches now and then.
        if (n % 15 == 0) no_idle = ($urandom_range(0, 3) == 0);
        // Midway through one phase, wait for the block to empty out.
        if (p == 3 && n == PHASE_ITEMS / 2) drain_results();
        r = $urandom_range(0, 99);
        if (r < ins_w) begin
          send_cmd(make_cmd(OP_INSERT, random_value()));
        end else if (r < ins_w + del_w) begin
          send_cmd(make_cmd(OP_DELETE, $urandom));
        end else if (r < 97) begin
          if (fill_count > 0 && $urandom_range(0, 9) < 6)
            val = stored_at($urandom_range(0, fill_count - 1));
          else
            val = random_value();
          send_cmd(make_cmd(OP_SEARCH, val));
        end else begin
          send_cmd(make_cmd(OP_NOP, $urandom));
        end
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_capacity_edges();
    test_random_traffic();
    drain_results();
    repeat (25) @(posedge clk);
    $display("Sent %0d commands: %0d ok, %0d full, %0d empty, %0d not found.",
             cmd_count, status_seen[ST_OK], status_seen[ST_FULL],
             status_seen[ST_EMPTY], status_seen[ST_NOT_FOUND]);
    $display("Capacities from 0 to 31 were used, with random stalls on both sides.");
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
